// ----- hdl/exprtok_pkg.sv -----
// ----------------------------------------------------------------------------
// Expression tokenizer package
// Shared field widths, token kind codes and the token and result types.
// ----------------------------------------------------------------------------
package exprtok_pkg;

    localparam int OFFSET_BITS_DEF = 16;
    localparam int FIELD_BITS      = 16;
    localparam int KIND_BITS       = 5;
    localparam int Q_DEPTH         = 4;
    localparam int Q_PTR_BITS      = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS      = $clog2(Q_DEPTH + 1);

    localparam logic [KIND_BITS-1:0] K_END    = 5'd0;
    localparam logic [KIND_BITS-1:0] K_NUM    = 5'd1;
    localparam logic [KIND_BITS-1:0] K_IDENT  = 5'd2;
    localparam logic [KIND_BITS-1:0] K_LET    = 5'd3;
    localparam logic [KIND_BITS-1:0] K_FUN    = 5'd4;
    localparam logic [KIND_BITS-1:0] K_PLUS   = 5'd5;
    localparam logic [KIND_BITS-1:0] K_MINUS  = 5'd6;
    localparam logic [KIND_BITS-1:0] K_STAR   = 5'd7;
    localparam logic [KIND_BITS-1:0] K_SLASH  = 5'd8;
    localparam logic [KIND_BITS-1:0] K_CARET  = 5'd9;
    localparam logic [KIND_BITS-1:0] K_LPAREN = 5'd10;
    localparam logic [KIND_BITS-1:0] K_RPAREN = 5'd11;
    localparam logic [KIND_BITS-1:0] K_LBRACE = 5'd12;
    localparam logic [KIND_BITS-1:0] K_RBRACE = 5'd13;
    localparam logic [KIND_BITS-1:0] K_COMMA  = 5'd14;
    localparam logic [KIND_BITS-1:0] K_EQUAL  = 5'd15;
    localparam logic [KIND_BITS-1:0] K_ERROR  = 5'd16;

    typedef struct packed {
        logic [KIND_BITS-1:0]  kind;
        logic [FIELD_BITS-1:0] start;
        logic [FIELD_BITS-1:0] length;
        logic                  last;
    } t_tok;

    typedef struct packed {
        logic [1:0] count;
        t_tok       tok0;
        t_tok       tok1;
    } t_scan_res;

endpackage

// ----- hdl/exprtok_scan.sv -----
// ----------------------------------------------------------------------------
// Expression tokenizer scanner
// Holds the lexer state and turns one accepted beat into up to two tokens.
// ----------------------------------------------------------------------------
module exprtok_scan #(
    parameter int OFFSET_BITS = exprtok_pkg::OFFSET_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fire,
    input  logic                   i_mode,
    input  logic [7:0]             i_text_byte,
    output exprtok_pkg::t_scan_res o_res
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INT,
        ST_DOT,
        ST_FRAC,
        ST_IDENT,
        ST_ERROR
    } t_scan_state;

    localparam logic [2:0]  NO_MATCH = 3'd7;
    localparam logic [2:0]  KW_DONE  = 3'd3;
    localparam logic [23:0] KW_LET   = "let";
    localparam logic [23:0] KW_FUN   = "fun";
    localparam logic [7:0]  CH_DOT   = ".";
    localparam logic [7:0]  CH_UNDER = "_";

    t_scan_state            r_state, n_state;
    logic [OFFSET_BITS-1:0] r_begin, n_begin;
    logic [OFFSET_BITS-1:0] r_offset, n_offset;
    logic [2:0]             r_let, n_let;
    logic [2:0]             r_fun, n_fun;

    function automatic logic [2:0] adv(input logic [2:0] prog, input logic [23:0] kw,
                                       input logic [7:0] c);
        logic [7:0] ch;
        case (prog)
            3'd0:    ch = kw[23:16];
            3'd1:    ch = kw[15:8];
            default: ch = kw[7:0];
        endcase
        return (prog < KW_DONE && ch == c) ? prog + 3'd1 : NO_MATCH;
    endfunction

    function automatic exprtok_pkg::t_tok mk(input logic [exprtok_pkg::KIND_BITS-1:0] kind,
                                             input logic [OFFSET_BITS-1:0] start,
                                             input logic [OFFSET_BITS-1:0] len);
        exprtok_pkg::t_tok t;
        t.kind   = kind;
        t.start  = exprtok_pkg::FIELD_BITS'(start);
        t.length = exprtok_pkg::FIELD_BITS'(len);
        t.last   = 1'b0;
        return t;
    endfunction

    function automatic logic [exprtok_pkg::KIND_BITS-1:0] op_kind(input logic [7:0] c);
        logic [exprtok_pkg::KIND_BITS-1:0] k;
        unique case (c)
            "+":     k = exprtok_pkg::K_PLUS;
            "-":     k = exprtok_pkg::K_MINUS;
            "*":     k = exprtok_pkg::K_STAR;
            "/":     k = exprtok_pkg::K_SLASH;
            "^":     k = exprtok_pkg::K_CARET;
            "(":     k = exprtok_pkg::K_LPAREN;
            ")":     k = exprtok_pkg::K_RPAREN;
            "{":     k = exprtok_pkg::K_LBRACE;
            "}":     k = exprtok_pkg::K_RBRACE;
            ",":     k = exprtok_pkg::K_COMMA;
            "=":     k = exprtok_pkg::K_EQUAL;
            default: k = exprtok_pkg::K_END;
        endcase
        return k;
    endfunction

    logic [7:0]                        c;
    logic                              is_digit, is_alpha, is_space;
    logic [OFFSET_BITS-1:0]            pos, dot, span_pos, span_dot, one;
    logic [exprtok_pkg::KIND_BITS-1:0] id_kind, op_k;
    exprtok_pkg::t_tok                 tok0, tok1, tokx;
    logic [1:0]                        cnt;
    t_scan_state                       st1;
    logic                              emit_x;

    assign c        = i_text_byte;
    assign is_digit = (c >= "0") && (c <= "9");
    assign is_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"))
                      || (c == CH_UNDER);
    assign is_space = (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
    assign pos      = r_offset;
    assign one      = OFFSET_BITS'(1);
    assign dot      = (pos != '0) ? pos - one : '0;
    assign span_pos = (pos >= r_begin) ? pos - r_begin : '0;
    assign span_dot = (dot >= r_begin) ? dot - r_begin : '0;
    assign op_k     = op_kind(c);
    assign id_kind  = (r_let == KW_DONE) ? exprtok_pkg::K_LET :
                      (r_fun == KW_DONE) ? exprtok_pkg::K_FUN : exprtok_pkg::K_IDENT;

    always_comb begin
        n_state  = r_state;
        n_begin  = r_begin;
        n_offset = r_offset;
        n_let    = r_let;
        n_fun    = r_fun;
        tok0     = '0;
        tok1     = '0;
        tokx     = '0;
        cnt      = 2'd0;
        st1      = r_state;
        emit_x   = 1'b0;
        if (i_mode) begin
            unique case (r_state)
                ST_ERROR: begin
                end
                ST_DOT: begin
                    tok0 = mk(exprtok_pkg::K_NUM, r_begin, span_dot);
                    tok1 = mk(exprtok_pkg::K_ERROR, dot, one);
                    cnt  = 2'd2;
                end
                ST_INT, ST_FRAC: begin
                    tok0 = mk(exprtok_pkg::K_NUM, r_begin, span_pos);
                    tok1 = mk(exprtok_pkg::K_END, pos, '0);
                    cnt  = 2'd2;
                end
                ST_IDENT: begin
                    tok0 = mk(id_kind, r_begin, span_pos);
                    tok1 = mk(exprtok_pkg::K_END, pos, '0);
                    cnt  = 2'd2;
                end
                default: begin
                    tok0 = mk(exprtok_pkg::K_END, pos, '0);
                    cnt  = 2'd1;
                end
            endcase
            n_state  = ST_IDLE;
            n_begin  = '0;
            n_offset = '0;
            n_let    = 3'd0;
            n_fun    = 3'd0;
        end else begin
            unique case (r_state)
                ST_ERROR: begin
                end
                ST_DOT: begin
                    if (is_digit) begin
                        st1 = ST_FRAC;
                    end else begin
                        tok0 = mk(exprtok_pkg::K_NUM, r_begin, span_dot);
                        tok1 = mk(exprtok_pkg::K_ERROR, dot, one);
                        cnt  = 2'd2;
                        st1  = ST_ERROR;
                    end
                end
                ST_INT, ST_FRAC: begin
                    if (is_digit) begin
                    end else if (c == CH_DOT && r_state == ST_INT) begin
                        st1 = ST_DOT;
                    end else begin
                        tok0 = mk(exprtok_pkg::K_NUM, r_begin, span_pos);
                        cnt  = 2'd1;
                        st1  = ST_IDLE;
                    end
                end
                ST_IDENT: begin
                    if (is_alpha || is_digit) begin
                        n_let = adv(r_let, KW_LET, c);
                        n_fun = adv(r_fun, KW_FUN, c);
                    end else begin
                        tok0 = mk(id_kind, r_begin, span_pos);
                        cnt  = 2'd1;
                        st1  = ST_IDLE;
                    end
                end
                default: begin
                    st1 = ST_IDLE;
                end
            endcase
            if (st1 == ST_IDLE) begin
                if (is_space) begin
                end else if (is_digit) begin
                    st1     = ST_INT;
                    n_begin = pos;
                end else if (is_alpha) begin
                    st1     = ST_IDENT;
                    n_begin = pos;
                    n_let   = adv(3'd0, KW_LET, c);
                    n_fun   = adv(3'd0, KW_FUN, c);
                end else if (op_k != exprtok_pkg::K_END) begin
                    tokx   = mk(op_k, pos, one);
                    emit_x = 1'b1;
                end else begin
                    tokx   = mk(exprtok_pkg::K_ERROR, pos, one);
                    emit_x = 1'b1;
                    st1    = ST_ERROR;
                end
            end
            if (emit_x) begin
                if (cnt == 2'd0) begin
                    tok0 = tokx;
                end else begin
                    tok1 = tokx;
                end
                cnt = cnt + 2'd1;
            end
            n_state = st1;
            if (r_offset != '1) begin
                n_offset = r_offset + one;
            end
        end
        if (cnt == 2'd1) begin
            tok0.last = 1'b1;
        end
        if (cnt == 2'd2) begin
            tok1.last = 1'b1;
        end
    end

    assign o_res.count = i_fire ? cnt : 2'd0;
    assign o_res.tok0  = tok0;
    assign o_res.tok1  = tok1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_begin  <= '0;
            r_offset <= '0;
            r_let    <= 3'd0;
            r_fun    <= 3'd0;
        end else if (i_fire) begin
            r_state  <= n_state;
            r_begin  <= n_begin;
            r_offset <= n_offset;
            r_let    <= n_let;
            r_fun    <= n_fun;
        end
    end

endmodule

// ----- hdl/exprtok_outq.sv -----
// ----------------------------------------------------------------------------
// Expression tokenizer result queue
// Small register queue that takes up to two tokens per cycle and gives one while i_ready is high.
// ----------------------------------------------------------------------------
module exprtok_outq (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  exprtok_pkg::t_scan_res i_res,
    output logic                   o_room,
    output logic                   o_valid,
    input  logic                   i_ready,
    output exprtok_pkg::t_tok      o_tok
);

    exprtok_pkg::t_tok                  r_mem [exprtok_pkg::Q_DEPTH];
    logic [exprtok_pkg::Q_PTR_BITS-1:0] r_wr, r_rd;
    logic [exprtok_pkg::Q_CNT_BITS-1:0] r_cnt;
    logic                               pop;

    assign o_valid = (r_cnt != '0);
    assign o_tok   = r_mem[r_rd];
    assign pop     = o_valid && i_ready;
    assign o_room  = (r_cnt <= exprtok_pkg::Q_CNT_BITS'(exprtok_pkg::Q_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (i_res.count != 2'd0) begin
            r_mem[r_wr] <= i_res.tok0;
        end
        if (i_res.count == 2'd2) begin
            r_mem[r_wr + exprtok_pkg::Q_PTR_BITS'(1)] <= i_res.tok1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + exprtok_pkg::Q_PTR_BITS'(i_res.count);
            r_rd  <= r_rd + exprtok_pkg::Q_PTR_BITS'(pop);
            r_cnt <= r_cnt + exprtok_pkg::Q_CNT_BITS'(i_res.count)
                     - exprtok_pkg::Q_CNT_BITS'(pop);
        end
    end

endmodule

// ----- hdl/expression_tokenizer_top.sv -----
// Tokens are registered in the result queue before they reach the output.
// Throughput: one input beat per cycle while o_ready is high; the output gives
// one token per cycle while i_ready is high. A beat that causes two tokens puts both
// into a four-entry result queue, and input is held off while fewer than two entries are free.
// Reset is synchronous and active low; it clears the scanner state and the queue.
// ----------------------------------------------------------------------------
// Expression tokenizer top level
// Streaming lexer: text bytes in, tokens with kind, start and length out.
// ----------------------------------------------------------------------------
module expression_tokenizer_top #(
    parameter int OFFSET_BITS = exprtok_pkg::OFFSET_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_mode,
    input  logic [7:0]  i_text_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [4:0]  o_token_kind,
    output logic [15:0] o_token_start,
    output logic [15:0] o_token_length,
    output logic        o_last_of_item
);

    exprtok_pkg::t_scan_res res;
    exprtok_pkg::t_tok      tok;
    logic                   room;
    logic                   fire;

    assign o_ready = room;
    assign fire    = i_valid && room;

    exprtok_scan #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_mode     (i_mode),
        .i_text_byte(i_text_byte),
        .o_res      (res)
    );

    exprtok_outq u_outq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_res  (res),
        .o_room (room),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_tok  (tok)
    );

    assign o_token_kind   = tok.kind;
    assign o_token_start  = tok.start;
    assign o_token_length = tok.length;
    assign o_last_of_item = tok.last;

endmodule

// ----- hdl/exprtok_chk.sv -----
// ----------------------------------------------------------------------------
// Expression tokenizer checker
// Port-level assertions on the tokenizer, attached to the top level by bind.
// ----------------------------------------------------------------------------
module exprtok_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [4:0]  o_token_kind,
    input logic [15:0] o_token_start,
    input logic [15:0] o_token_length,
    input logic        o_last_of_item
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_token_kind)
        && $stable(o_token_start) && $stable(o_token_length) && $stable(o_last_of_item))
        else $error("token beat changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> o_ready && !o_valid)
        else $error("queue not empty after reset");

    a_end_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_token_kind == exprtok_pkg::K_END |-> o_token_length == 16'd0
        && o_last_of_item)
        else $error("end token malformed");

    a_error_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_token_kind == exprtok_pkg::K_ERROR |-> o_token_length == 16'd1
        && o_last_of_item)
        else $error("error token malformed");

endmodule

bind expression_tokenizer_top exprtok_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_token_kind  (o_token_kind),
    .o_token_start (o_token_start),
    .o_token_length(o_token_length),
    .o_last_of_item(o_last_of_item)
);
